// File: rtl/etf_pkg.sv
// Shared constants, types and helpers of the escaped transmit-16 frame encoder.
`default_nettype none
package etf_pkg;

  localparam logic [7:0] FrameStart = 8'h7E;
  localparam logic [7:0] EscByte    = 8'h7D;
  localparam logic [7:0] XonByte    = 8'h11;
  localparam logic [7:0] XoffByte   = 8'h13;
  localparam logic [7:0] EscXor     = 8'h20;
  localparam logic [7:0] CmdTx16    = 8'h01;
  localparam logic [7:0] LenHigh    = 8'h00;
  localparam logic [7:0] PayloadLen = 8'h10;
  localparam logic [7:0] ChkBase    = 8'hFF;

  localparam int NumPay = 16;

  // Byte positions inside a frame, before escaping.
  localparam int          IdxW     = 5;
  localparam logic [IdxW-1:0] IdxStart = 5'd0;
  localparam logic [IdxW-1:0] IdxLenHi = 5'd1;
  localparam logic [IdxW-1:0] IdxLenLo = 5'd2;
  localparam logic [IdxW-1:0] IdxPay0  = 5'd3;
  localparam logic [IdxW-1:0] IdxChk   = 5'd19;

  localparam int              QPtrW  = 1;
  localparam int              QCntW  = 2;
  localparam logic [QCntW-1:0] QDepth = 2'd2;

  localparam int CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_ID   = 1'b0,
    CFG_TX_OPTIONS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [NumPay-1:0][7:0] pay;   // pay[0] goes out first
    logic [NumPay-1:0]      esc;   // byte needs an escape pair
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic must_escape(input logic [7:0] b);
    return (b == FrameStart) || (b == EscByte) || (b == XonByte) || (b == XoffByte);
  endfunction

endpackage
`default_nettype wire

// File: rtl/etf_if.sv
// Valid/ready channel interfaces for message input and byte output.
`default_nettype none
interface etf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] dest_addr;
  logic [7:0]  header_byte;
  logic [7:0]  first_type;
  logic [31:0] first_value;
  logic [7:0]  second_type;
  logic [31:0] second_value;

  modport source (output valid, dest_addr, header_byte, first_type, first_value,
                  second_type, second_value, input ready);
  modport sink   (input valid, dest_addr, header_byte, first_type, first_value,
                  second_type, second_value, output ready);
endinterface

interface etf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink   (input valid, out_byte, frame_end, output ready);
endinterface
`default_nettype wire

// File: rtl/escaped_tx16_frame_encoder_top.sv
// Top level of the escaped transmit-16 API frame encoder.
// Each accepted message becomes one frame of 20 to 36 output beats: delimiter, two length
// bytes, 16 payload bytes and the checksum, with payload and checksum bytes escaped as
// needed; frame_end marks the final beat. The serializer emits one beat per cycle while the
// output accepts beats. Messages are accepted into a two-frame queue; the frame being
// serialized keeps its slot until its last beat is issued, so one more message can be
// taken while the serializer is busy or the output is stalled. frame_id and tx_options
// are sampled when a message is accepted.
`default_nettype none
module escaped_tx16_frame_encoder_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  etf_in_if.sink                           in_chan,
  etf_out_if.source                        out_chan,
  input  wire logic                        cfg_we,
  input  wire logic [etf_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire logic [7:0]                  cfg_wdata
);

  etf_pkg::q_stat_t q_stat;
  etf_pkg::frame_t  push_data;
  etf_pkg::frame_t  head;
  logic             push;
  logic             pop;

  etf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  etf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_stat    (q_stat),
    .head      (head)
  );

  etf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

// File: rtl/etf_front.sv
// Front end: config registers, message accept, payload assembly and escape marking.
`default_nettype none
module etf_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  etf_in_if.sink                           in_chan,
  input  wire logic                        cfg_we,
  input  wire logic [etf_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire logic [7:0]                  cfg_wdata,
  input  wire etf_pkg::q_stat_t            q_stat,
  output logic                             push,
  output etf_pkg::frame_t                  push_data
);

  logic [7:0] frame_id_r;
  logic [7:0] tx_options_r;
  logic [etf_pkg::NumPay-1:0][7:0] pay;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_id_r   <= 8'h01;
      tx_options_r <= 8'h00;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        etf_pkg::CFG_FRAME_ID:   frame_id_r   <= cfg_wdata;
        etf_pkg::CFG_TX_OPTIONS: tx_options_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_chan.ready = !q_stat.full;
  assign push          = in_chan.valid && !q_stat.full;

  always_comb begin
    pay[0]  = etf_pkg::CmdTx16;
    pay[1]  = frame_id_r;
    pay[2]  = in_chan.dest_addr[15:8];
    pay[3]  = in_chan.dest_addr[7:0];
    pay[4]  = tx_options_r;
    pay[5]  = in_chan.header_byte;
    pay[6]  = in_chan.first_type;
    pay[7]  = in_chan.first_value[31:24];
    pay[8]  = in_chan.first_value[23:16];
    pay[9]  = in_chan.first_value[15:8];
    pay[10] = in_chan.first_value[7:0];
    pay[11] = in_chan.second_type;
    pay[12] = in_chan.second_value[31:24];
    pay[13] = in_chan.second_value[23:16];
    pay[14] = in_chan.second_value[15:8];
    pay[15] = in_chan.second_value[7:0];
  end

  always_comb begin
    push_data.pay = pay;
    for (int i = 0; i < etf_pkg::NumPay; i++) begin
      push_data.esc[i] = etf_pkg::must_escape(pay[i]);
    end
  end

endmodule
`default_nettype wire

// File: rtl/etf_queue.sv
// Two-entry frame queue between front end and serializer.
`default_nettype none
module etf_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire etf_pkg::frame_t   push_data,
  input  wire logic              pop,
  output etf_pkg::q_stat_t       q_stat,
  output etf_pkg::frame_t        head
);

  etf_pkg::frame_t mem [2**etf_pkg::QPtrW];

  logic [etf_pkg::QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [etf_pkg::QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [etf_pkg::QCntW-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == etf_pkg::QDepth);
  assign q_stat.empty = (count_r == '0);
  assign head         = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= etf_pkg::QDepth)
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// File: rtl/etf_back.sv
// Serializer: walks the head frame byte by byte, escapes, sums and appends the checksum.
`default_nettype none
module etf_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire etf_pkg::q_stat_t  q_stat,
  input  wire etf_pkg::frame_t   head,
  output logic                   pop,
  etf_out_if.source              out_chan
);

  logic [etf_pkg::IdxW-1:0] idx_r, idx_nxt;
  logic                     esc_r, esc_nxt;
  logic [7:0]               sum_r, sum_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic [7:0]               out_byte_r, out_byte_nxt;
  logic                     out_end_r, out_end_nxt;

  logic [etf_pkg::IdxW-1:0] pay_sel;
  logic [7:0]               raw;
  logic                     need_esc;
  logic                     is_pay;
  logic                     last;
  logic                     advance;

  assign pay_sel = idx_r - etf_pkg::IdxPay0;
  assign is_pay  = (idx_r >= etf_pkg::IdxPay0) && (idx_r < etf_pkg::IdxChk);

  always_comb begin
    raw      = etf_pkg::ChkBase - sum_r;
    need_esc = 1'b0;
    unique case (idx_r)
      etf_pkg::IdxStart: raw = etf_pkg::FrameStart;
      etf_pkg::IdxLenHi: raw = etf_pkg::LenHigh;
      etf_pkg::IdxLenLo: raw = etf_pkg::PayloadLen;
      etf_pkg::IdxChk: begin
        raw      = etf_pkg::ChkBase - sum_r;
        need_esc = etf_pkg::must_escape(raw);
      end
      default: begin
        raw      = head.pay[pay_sel[3:0]];
        need_esc = head.esc[pay_sel[3:0]];
      end
    endcase
  end

  assign advance = !q_stat.empty && (!out_vld_r || out_chan.ready);
  assign last    = (idx_r == etf_pkg::IdxChk) && (esc_r || !need_esc);
  assign pop     = advance && last;

  always_comb begin
    idx_nxt      = idx_r;
    esc_nxt      = esc_r;
    sum_nxt      = sum_r;
    out_vld_nxt  = out_vld_r && !out_chan.ready;
    out_byte_nxt = out_byte_r;
    out_end_nxt  = out_end_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
      out_end_nxt = last;
      if (esc_r) begin
        out_byte_nxt = raw ^ etf_pkg::EscXor;
      end else if (need_esc) begin
        out_byte_nxt = etf_pkg::EscByte;
      end else begin
        out_byte_nxt = raw;
      end

      if (!esc_r && need_esc) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (is_pay) begin
          sum_nxt = sum_r + raw;
        end
        if (last) begin
          idx_nxt = etf_pkg::IdxStart;
          sum_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= etf_pkg::IdxStart;
      esc_r     <= 1'b0;
      sum_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      esc_r     <= esc_nxt;
      sum_r     <= sum_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.out_byte  = out_byte_r;
  assign out_chan.frame_end = out_end_r;

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= etf_pkg::IdxChk)
    else $error("byte index past checksum");
  a_esc_range: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (idx_r >= etf_pkg::IdxPay0))
    else $error("escape pending on an unescaped header byte");
  a_esc_lead: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (out_vld_r && (out_byte_r == etf_pkg::EscByte) && !out_end_r))
    else $error("escape second half without a lead byte in the output stage");
  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (idx_r == etf_pkg::IdxStart) && !esc_r && (sum_r == '0))
    else $error("frame end did not restart the serializer");
`endif

endmodule
`default_nettype wire
